### rtl/hrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrf_pkg: shared types and constants of the HTTP request framer
// Request and response transfer types, length-parse phases, character
// codes and the header name that carries the message length.
// ----------------------------------------------------------------------------
package hrf_pkg;

	// Width of the internal length accumulator and body counter
	localparam int LENGTH_BITS = 32;
	// Width of the reported length field
	localparam int CL_W        = 32;
	// Characters in "content-length:"
	localparam int NAME_LEN    = 15;
	localparam int NAME_IDX_W  = $clog2(NAME_LEN + 1);

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_UP_A  = 8'h41;
	localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
	localparam logic [7:0] CASE_GAP   = 8'h20;

	// Command codes on the request channel
	localparam logic CMD_DATA  = 1'b0;
	localparam logic CMD_CLOSE = 1'b1;

	// Progress of the length header parse
	typedef enum logic [1:0] {
		LP_NAME,
		LP_BLANK,
		LP_DIGITS,
		LP_DONE
	} len_phase_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [7:0]      out_byte;
		logic            in_status_line;
		logic            header_end;
		logic            body_byte;
		logic            message_end;
		logic [CL_W-1:0] body_length;
		logic            length_saturated;
	} rsp_t;

	// Lower-case header name, one character per index
	function automatic logic [7:0] name_char(input logic [NAME_IDX_W-1:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0:    c = 8'h63; // c
			4'd1:    c = 8'h6F; // o
			4'd2:    c = 8'h6E; // n
			4'd3:    c = 8'h74; // t
			4'd4:    c = 8'h65; // e
			4'd5:    c = 8'h6E; // n
			4'd6:    c = 8'h74; // t
			4'd7:    c = 8'h2D; // -
			4'd8:    c = 8'h6C; // l
			4'd9:    c = 8'h65; // e
			4'd10:   c = 8'h6E; // n
			4'd11:   c = 8'h67; // g
			4'd12:   c = 8'h74; // t
			4'd13:   c = 8'h68; // h
			4'd14:   c = 8'h3A; // :
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### rtl/hrf_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrf_core: per-byte framing state and classification
// Holds the terminator, name and length matchers and the body counter,
// updates them on each step, one request per cycle, and forms its response.
// ----------------------------------------------------------------------------
module hrf_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  hrf_pkg::req_t item,
	output hrf_pkg::rsp_t result
);

	localparam int LB = hrf_pkg::LENGTH_BITS;

	logic [1:0]                     term_q, term_d;
	logic [hrf_pkg::NAME_IDX_W-1:0] name_q, name_d;
	hrf_pkg::len_phase_t            phase_q, phase_d;
	logic [LB-1:0]                  value_q, value_d;
	logic                           first_q, first_d;
	logic                           hdrs_q, hdrs_d;
	logic [LB-1:0]                  left_q, left_d;
	logic                           clamp_q, clamp_d;

	logic [7:0]    b;
	logic [7:0]    lb;
	logic          is_cr, is_lf, is_blank, is_digit, is_close;
	logic [LB+3:0] wide;
	logic          ovf;
	logic          term_done;
	logic          body_last;
	logic          msg_end;

	// Decode the byte
	assign b        = item.data_byte;
	assign lb       = (b >= hrf_pkg::CHAR_UP_A && b <= hrf_pkg::CHAR_UP_Z) ?
	                  b + hrf_pkg::CASE_GAP : b;
	assign is_close = (item.cmd == hrf_pkg::CMD_CLOSE);
	assign is_cr    = (b == hrf_pkg::CHAR_CR);
	assign is_lf    = (b == hrf_pkg::CHAR_LF);
	assign is_blank = (b == hrf_pkg::CHAR_SPACE) || (b == hrf_pkg::CHAR_TAB);
	assign is_digit = (b >= hrf_pkg::CHAR_ZERO) && (b <= hrf_pkg::CHAR_NINE);

	// Multiply by ten and add the digit; any carry out of the field saturates
	assign wide = ({4'b0, value_q} << 3) + ({4'b0, value_q} << 1)
	            + (LB+4)'(b - hrf_pkg::CHAR_ZERO);
	assign ovf  = |wide[LB+3:LB];

	assign term_done = !hdrs_q && is_lf && (term_q == 2'd3);
	assign body_last = hdrs_q && (left_q <= LB'(1));
	assign msg_end   = !is_close && (body_last || (term_done && value_q == '0));

	// Next state
	always_comb begin
		term_d  = term_q;
		name_d  = name_q;
		phase_d = phase_q;
		value_d = value_q;
		first_d = first_q;
		hdrs_d  = hdrs_q;
		left_d  = left_q;
		clamp_d = clamp_q;
		if (!is_close && hdrs_q) begin
			left_d = left_q - LB'(1);
		end else if (!is_close) begin
			if (first_q && is_lf && term_q[0]) begin
				first_d = 1'b0;
			end
			unique case (phase_q)
				hrf_pkg::LP_NAME: begin
					if (lb == hrf_pkg::name_char(name_q)) begin
						if (name_q == hrf_pkg::NAME_IDX_W'(hrf_pkg::NAME_LEN - 1)) begin
							phase_d = hrf_pkg::LP_BLANK;
							name_d  = '0;
						end else begin
							name_d = name_q + hrf_pkg::NAME_IDX_W'(1);
						end
					end else begin
						name_d = (lb == hrf_pkg::name_char('0)) ?
						         hrf_pkg::NAME_IDX_W'(1) : '0;
					end
				end
				hrf_pkg::LP_BLANK, hrf_pkg::LP_DIGITS: begin
					if (phase_q == hrf_pkg::LP_BLANK && is_blank) begin
						phase_d = phase_q;
					end else if (is_digit) begin
						phase_d = hrf_pkg::LP_DIGITS;
						if (ovf) begin
							value_d = hrf_pkg::LEN_MAX;
							clamp_d = 1'b1;
						end else begin
							value_d = wide[LB-1:0];
						end
					end else begin
						phase_d = hrf_pkg::LP_DONE;
					end
				end
				hrf_pkg::LP_DONE: begin
					phase_d = phase_q;
				end
			endcase
			// Track the blank-line terminator
			priority if (is_cr) begin
				term_d = (term_q == 2'd2) ? 2'd3 : 2'd1;
			end else if (is_lf && term_q == 2'd1) begin
				term_d = 2'd2;
			end else if (term_done) begin
				term_d  = 2'd0;
				name_d  = '0;
				phase_d = hrf_pkg::LP_DONE;
				hdrs_d  = 1'b1;
				left_d  = value_q;
			end else begin
				term_d = 2'd0;
			end
		end
		// Start a fresh message on close or when the message completes
		if (is_close || msg_end) begin
			term_d  = 2'd0;
			name_d  = '0;
			phase_d = hrf_pkg::LP_NAME;
			value_d = '0;
			first_d = 1'b1;
			hdrs_d  = 1'b0;
			left_d  = '0;
			clamp_d = 1'b0;
		end
	end

	// Response fields
	always_comb begin
		result                  = '0;
		result.out_byte         = is_close ? 8'h00 : b;
		result.in_status_line   = !is_close && !hdrs_q && first_q;
		result.header_end       = !is_close && term_done;
		result.body_byte        = !is_close && hdrs_q;
		result.message_end      = msg_end;
		result.body_length      = (!is_close && term_done) ?
		                          hrf_pkg::CL_W'(value_q) : '0;
		result.length_saturated = !is_close && term_done && clamp_q;
	end

	// Advance the framing state once per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q  <= 2'd0;
			name_q  <= '0;
			phase_q <= hrf_pkg::LP_NAME;
			value_q <= '0;
			first_q <= 1'b1;
			hdrs_q  <= 1'b0;
			left_q  <= '0;
			clamp_q <= 1'b0;
		end else if (step) begin
			term_q  <= term_d;
			name_q  <= name_d;
			phase_q <= phase_d;
			value_q <= value_d;
			first_q <= first_d;
			hdrs_q  <= hdrs_d;
			left_q  <= left_d;
			clamp_q <= clamp_d;
		end
	end

endmodule

### rtl/http_request_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_framer: HTTP/1.1 request framing by Content-Length
// Tags each request byte as status line, header end, body or message end
// and reports the parsed body length at the header end.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one transfer per byte (cmd = data) or a connection close
//   (cmd = close, which clears all framing state). rsp channel: exactly one
//   transfer per request transfer, in order.
//   Path: an accepted request passes the input register, then one pass of
//   matcher and counter logic, into the two-entry response buffer and rsp.
//   Throughput: one byte per cycle while req_stall is low; every byte
//   reads and writes the framing state in that single pass, so the state
//   update sets the rate.
//   Stall: while rsp_stall is high the head response holds; the buffer
//   still takes one more response, and req_stall rises only once both
//   buffer entries and the input register are full.
//   Reset: arst_n clears the buffer and the framing state; the first byte
//   after reset starts a new message in its status line.
// ----------------------------------------------------------------------------
module http_request_framer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  hrf_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output hrf_pkg::rsp_t rsp
);

	logic          valid_s1;
	hrf_pkg::req_t item_s1;
	hrf_pkg::rsp_t result;
	hrf_pkg::rsp_t buf_q [2];
	logic [1:0]    count_q;
	logic          rd_q, wr_q;
	logic          full, push, pop;

	assign full      = (count_q == 2'd2);
	assign push      = valid_s1 && !full;
	assign pop       = (count_q != 2'd0) && !rsp_stall;
	assign req_stall = valid_s1 && full;
	assign rsp_valid = (count_q != 2'd0);
	assign rsp       = buf_q[rd_q];

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			item_s1 <= req;
		end
	end

	hrf_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (push),
		.item   (item_s1),
		.result (result)
	);

	// Response buffer pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			rd_q    <= 1'b0;
			wr_q    <= 1'b0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
		end
	end

	// Hold responses until transferred
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= result;
		end
	end

endmodule

### rtl/hrf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrf_checker: port-level checks of the HTTP request framer
// Watches the response channel for handshake and tagging consistency.
// ----------------------------------------------------------------------------
module hrf_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input hrf_pkg::rsp_t rsp
);

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// Stall requests only while responses are waiting
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid)
		else $error("request stalled with no response pending");

	// Report a length only at the header end
	a_len_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.header_end |->
			rsp.body_length == '0 && !rsp.length_saturated)
		else $error("length reported away from header end");

	// Keep body bytes apart from header bytes
	a_body_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.body_byte |-> !rsp.in_status_line && !rsp.header_end)
		else $error("body byte also tagged as header");

	// End a message only on a body byte or the header end
	a_end_source: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.message_end |-> rsp.body_byte || rsp.header_end)
		else $error("message end without body or header end");

endmodule

bind http_request_framer hrf_checker u_hrf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

### tb/http_request_framer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_framer_test: self-checking bench for the HTTP request framer
// Sends a short directed run of requests, then random request streams. Most
// of the random traffic is well-formed messages with random content; the
// rest is noise, stray closes and cut-off messages. It runs under three
// idle/stall mixes and checks every response transfer, field by field,
// against a local model of the Content-Length framing rules.
// ----------------------------------------------------------------------------
module http_request_framer_test;

	localparam int              ITEMS_PER_PHASE = 600;
	localparam int              CYCLE_LIMIT     = 300000;
	localparam longint unsigned LEN_CAP         = hrf_pkg::LEN_MAX;

	// CR LF CR LF matcher progress
	localparam logic [1:0] SAW_NONE   = 2'd0;
	localparam logic [1:0] SAW_CR     = 2'd1;
	localparam logic [1:0] SAW_CRLF   = 2'd2;
	localparam logic [1:0] SAW_CRLFCR = 2'd3;

	typedef struct {
		hrf_pkg::req_t item;
		bit            fixed;
		hrf_pkg::rsp_t want;
	} dir_row_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	hrf_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	hrf_pkg::rsp_t rsp;

	// Framing model state
	logic [1:0]                     crlf_seen;
	logic [hrf_pkg::NAME_IDX_W-1:0] name_pos;
	hrf_pkg::len_phase_t            len_step;
	longint unsigned                parsed_len;
	logic                           in_first_line;
	logic                           in_body;
	longint unsigned                body_remaining;
	logic                           len_clamped;
	string                          len_name = "content-length:";

	// Bench state
	hrf_pkg::rsp_t due_tags[$];
	hrf_pkg::req_t byte_stream[$];
	dir_row_t      directed_rows[$];
	hrf_pkg::rsp_t next_tags;
	int            send_idle_pct  = 13;
	int            stall_pct      = 64;
	bit            row_fixed      = 1'b0;
	hrf_pkg::rsp_t row_want       = '0;
	int            mismatch_count = 0;
	int            cycle_count    = 0;

	http_request_framer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Clear framing state: the next byte opens a status line
	function automatic void clear_framing();
		crlf_seen      = SAW_NONE;
		name_pos       = '0;
		len_step       = hrf_pkg::LP_NAME;
		parsed_len     = 0;
		in_first_line  = 1'b1;
		in_body        = 1'b0;
		body_remaining = 0;
		len_clamped    = 1'b0;
	endfunction

	// Track the length header through name, blanks and digits
	function automatic void parse_length(logic [7:0] b);
		logic [7:0]      lower;
		longint unsigned digit;
		lower = (b >= hrf_pkg::CHAR_UP_A && b <= hrf_pkg::CHAR_UP_Z) ?
		        b + hrf_pkg::CASE_GAP : b;
		if (len_step == hrf_pkg::LP_NAME) begin
			if (lower == len_name[name_pos]) begin
				name_pos++;
				if (name_pos == hrf_pkg::NAME_LEN) begin
					len_step = hrf_pkg::LP_BLANK;
					name_pos = '0;
				end
			end else begin
				name_pos = (lower == len_name[0]) ? hrf_pkg::NAME_IDX_W'(1) : '0;
			end
		end else if (len_step == hrf_pkg::LP_BLANK
				&& (b == hrf_pkg::CHAR_SPACE || b == hrf_pkg::CHAR_TAB)) begin
			// skip blanks ahead of the digits
		end else if (len_step != hrf_pkg::LP_DONE) begin
			if (b >= hrf_pkg::CHAR_ZERO && b <= hrf_pkg::CHAR_NINE) begin
				digit    = 64'(b - hrf_pkg::CHAR_ZERO);
				len_step = hrf_pkg::LP_DIGITS;
				// clamp at the counter's top value
				if (parsed_len > (LEN_CAP - digit) / 10) begin
					parsed_len  = LEN_CAP;
					len_clamped = 1'b1;
				end else begin
					parsed_len = parsed_len * 10 + digit;
				end
			end else begin
				len_step = hrf_pkg::LP_DONE;
			end
		end
	endfunction

	// Tag one request transfer and advance the framing state
	function automatic hrf_pkg::rsp_t frame_byte(hrf_pkg::req_t r);
		hrf_pkg::rsp_t tags;
		logic [7:0]    b;
		tags = '0;
		b    = r.data_byte;
		if (r.cmd == hrf_pkg::CMD_CLOSE) begin
			clear_framing();
			return tags;
		end
		tags.out_byte = b;
		// count down the body, close the message on its last byte
		if (in_body) begin
			tags.body_byte = 1'b1;
			if (body_remaining > 0) begin
				body_remaining--;
			end
			if (body_remaining == 0) begin
				tags.message_end = 1'b1;
				clear_framing();
			end
			return tags;
		end
		if (in_first_line) begin
			tags.in_status_line = 1'b1;
			if (b == hrf_pkg::CHAR_LF && crlf_seen[0]) begin
				in_first_line = 1'b0;
			end
		end
		parse_length(b);
		// advance the blank-line matcher
		if (b == hrf_pkg::CHAR_CR) begin
			crlf_seen = (crlf_seen == SAW_CRLF) ? SAW_CRLFCR : SAW_CR;
		end else if (b == hrf_pkg::CHAR_LF && crlf_seen == SAW_CR) begin
			crlf_seen = SAW_CRLF;
		end else if (b == hrf_pkg::CHAR_LF && crlf_seen == SAW_CRLFCR) begin
			tags.header_end       = 1'b1;
			tags.body_length      = parsed_len[hrf_pkg::CL_W-1:0];
			tags.length_saturated = len_clamped;
			crlf_seen      = SAW_NONE;
			name_pos       = '0;
			len_step       = hrf_pkg::LP_DONE;
			in_body        = 1'b1;
			body_remaining = parsed_len;
			if (body_remaining == 0) begin
				tags.message_end = 1'b1;
				clear_framing();
			end
		end else begin
			crlf_seen = SAW_NONE;
		end
		return tags;
	endfunction

	function automatic hrf_pkg::rsp_t framing_tags(logic [7:0] b, logic status,
			logic hdr_end, logic body, logic msg_end, logic [hrf_pkg::CL_W-1:0] len);
		hrf_pkg::rsp_t tags;
		tags = '{out_byte: b, in_status_line: status, header_end: hdr_end, body_byte: body,
			message_end: msg_end, body_length: len, length_saturated: 1'b0};
		return tags;
	endfunction

	function automatic void add_row(logic cmd, logic [7:0] b, bit fixed, hrf_pkg::rsp_t want);
		hrf_pkg::req_t item;
		item = '{cmd: cmd, data_byte: b};
		directed_rows.push_back('{item: item, fixed: fixed, want: want});
	endfunction

	function automatic void add_byte(logic cmd, logic [7:0] b);
		byte_stream.push_back('{cmd: cmd, data_byte: b});
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			add_byte(hrf_pkg::CMD_DATA, s[i]);
		end
	endfunction

	function automatic string printable_text(int unsigned n);
		string s = "";
		repeat (n) s = {s, $sformatf("%c", $urandom_range(126, 33))};
		return s;
	endfunction

	// Build a length header in random case with blanks and a value of some
	// shape; return the length it should give and whether that is too big
	// for a full body
	function automatic string length_header(output longint unsigned value, output bit huge);
		string       txt;
		string       digits;
		int unsigned shape;
		int unsigned v;
		txt   = len_name;
		value = 0;
		huge  = 1'b0;
		for (int i = 0; i < txt.len(); i++) begin
			if (txt[i] >= hrf_pkg::CHAR_UP_A + hrf_pkg::CASE_GAP
					&& txt[i] <= hrf_pkg::CHAR_UP_Z + hrf_pkg::CASE_GAP
					&& $urandom_range(1) == 1) begin
				txt[i] = txt[i] - hrf_pkg::CASE_GAP;
			end
		end
		repeat ($urandom_range(2)) begin
			if ($urandom_range(1) == 1) begin
				txt = {txt, " "};
			end else begin
				txt = {txt, "\t"};
			end
		end
		shape = $urandom_range(99);
		if (shape < 55) begin
			value  = $urandom_range(24);
			digits = $sformatf("%0d", value);
			if ($urandom_range(4) == 0) begin
				digits = {"00", digits};
			end
		end else if (shape < 63) begin
			// no digits at all, or a sign or a letter in front of them
			case ($urandom_range(3))
				0:       digits = "";
				1:       digits = "+5";
				2:       digits = "-3";
				default: digits = "x7";
			endcase
		end else if (shape < 70) begin
			value  = LEN_CAP;
			huge   = 1'b1;
			digits = $sformatf("%0d", LEN_CAP);
		end else if (shape < 78) begin
			// more digits than the counter holds
			value  = LEN_CAP;
			huge   = 1'b1;
			digits = $sformatf("%0d%0d", LEN_CAP, $urandom);
		end else begin
			v      = $urandom;
			value  = v;
			huge   = (v > 24);
			digits = $sformatf("%0d", v);
		end
		// now and then end the digits with some other text
		if ($urandom_range(3) == 0) begin
			digits = {digits, " ;q"};
		end
		return {txt, digits};
	endfunction

	// Queue one random message, or a burst of noise, or a stray close
	function automatic void add_message();
		int unsigned     pick;
		int unsigned     n_hdr;
		int unsigned     len_slot;
		bit              want_len;
		bit              have_len;
		bit              huge;
		bit              huge_seen;
		bit              cut;
		longint unsigned value;
		longint unsigned body_len;
		string           pattern;
		string           hdr;
		pick = $urandom_range(99);
		if (pick < 6) begin
			repeat ($urandom_range(6, 1)) add_byte(hrf_pkg::CMD_DATA, 8'($urandom));
			return;
		end
		if (pick < 9) begin
			add_byte(hrf_pkg::CMD_CLOSE, 8'($urandom));
			return;
		end
		have_len  = 1'b0;
		huge_seen = 1'b0;
		body_len  = 0;
		// status line, now and then carrying the length name itself
		case ($urandom_range(2))
			0:       add_text("GET /");
			1:       add_text("POST /");
			default: add_text("PUT /");
		endcase
		add_text(printable_text($urandom_range(8)));
		if (pick < 14) begin
			hdr = length_header(body_len, huge_seen);
			add_text(hdr);
			have_len = 1'b1;
		end
		add_text(" HTTP/1.1\015\012");
		// header lines, the length header at a random slot
		n_hdr    = $urandom_range(3);
		len_slot = $urandom_range(n_hdr);
		want_len = ($urandom_range(3) != 0);
		for (int i = 0; i < n_hdr + want_len; i++) begin
			if (want_len && i == len_slot) begin
				hdr = length_header(value, huge);
				if (!have_len) begin
					body_len  = value;
					huge_seen = huge;
					have_len  = 1'b1;
				end
			end else begin
				case ($urandom_range(3))
					0:       hdr = "Host: ";
					1:       hdr = "X-Content-Length-Hint: ";
					2:       hdr = "Content-Type: ";
					default: hdr = "Accept:\t";
				endcase
				hdr = {hdr, printable_text($urandom_range(10))};
			end
			add_text({hdr, "\015\012"});
		end
		// drop the connection before the blank line now and then
		if ($urandom_range(24) == 0) begin
			add_byte(hrf_pkg::CMD_CLOSE, 8'($urandom));
			return;
		end
		add_text("\015\012");
		// a huge length gets a few body bytes and a close
		if (huge_seen) begin
			repeat ($urandom_range(4)) add_byte(hrf_pkg::CMD_DATA, 8'($urandom));
			add_byte(hrf_pkg::CMD_CLOSE, 8'($urandom));
			return;
		end
		// body mixes random bytes with header text that must not be parsed
		pattern = "Content-Length: 9\015\012\015\012";
		cut     = ($urandom_range(19) == 0 && body_len > 1);
		if (cut) begin
			body_len = body_len / 2;
		end
		for (int i = 0; i < int'(body_len); i++) begin
			if ($urandom_range(3) == 0) begin
				add_byte(hrf_pkg::CMD_DATA, pattern[i % pattern.len()]);
			end else begin
				add_byte(hrf_pkg::CMD_DATA, 8'($urandom));
			end
		end
		if (cut) begin
			add_byte(hrf_pkg::CMD_CLOSE, 8'($urandom));
		end
	endfunction

	function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			mismatch_count++;
			$error("%s: expected %0h, actual %0h", field, want, got);
		end
	endfunction

	function automatic void check_response(hrf_pkg::rsp_t want);
		check_field("out_byte", want.out_byte, rsp.out_byte);
		check_field("in_status_line", want.in_status_line, rsp.in_status_line);
		check_field("header_end", want.header_end, rsp.header_end);
		check_field("body_byte", want.body_byte, rsp.body_byte);
		check_field("message_end", want.message_end, rsp.message_end);
		check_field("body_length", want.body_length, rsp.body_length);
		check_field("length_saturated", want.length_saturated, rsp.length_saturated);
	endfunction

	// Present one request and hold it until its transfer
	task automatic send_item(hrf_pkg::req_t item, bit fixed, hrf_pkg::rsp_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		row_fixed  = fixed;
		row_want   = want;
		do begin
			@(posedge clk);
		end while (req_stall);
		@(negedge clk);
	endtask

	// Send one batch of random traffic, then drain every response
	task automatic run_phase();
		while (byte_stream.size() < ITEMS_PER_PHASE) begin
			add_message();
		end
		while (byte_stream.size() > 0) begin
			send_item(byte_stream.pop_front(), 1'b0, '0);
		end
		req_valid <= 1'b0;
		while (due_tags.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Stall the response side at random
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// Check each response transfer, predict each request transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (due_tags.size() == 0) begin
					mismatch_count++;
					$error("response transfer with no request pending");
				end else begin
					check_response(due_tags.pop_front());
				end
			end
			if (req_valid && !req_stall) begin
				next_tags = frame_byte(req);
				due_tags.push_back(row_fixed ? row_want : next_tags);
			end
		end
	end

	// Give up on a hung block
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		string lead;
		clear_framing();
		// bare request: extreme byte in the status line, empty headers, no body
		add_row(hrf_pkg::CMD_DATA, 8'hFF, 1'b1, framing_tags(8'hFF, 1, 0, 0, 0, 0));
		add_row(hrf_pkg::CMD_DATA, hrf_pkg::CHAR_CR, 1'b1,
			framing_tags(hrf_pkg::CHAR_CR, 1, 0, 0, 0, 0));
		add_row(hrf_pkg::CMD_DATA, hrf_pkg::CHAR_LF, 1'b1,
			framing_tags(hrf_pkg::CHAR_LF, 1, 0, 0, 0, 0));
		add_row(hrf_pkg::CMD_DATA, hrf_pkg::CHAR_CR, 1'b1,
			framing_tags(hrf_pkg::CHAR_CR, 0, 0, 0, 0, 0));
		add_row(hrf_pkg::CMD_DATA, hrf_pkg::CHAR_LF, 1'b1,
			framing_tags(hrf_pkg::CHAR_LF, 0, 1, 0, 1, 0));
		// length in the status line, a NUL body byte, then a close mid-body
		lead = "Content-Length:2\015\012\015";
		for (int i = 0; i < lead.len(); i++) begin
			add_row(hrf_pkg::CMD_DATA, lead[i], 1'b0, '0);
		end
		add_row(hrf_pkg::CMD_DATA, hrf_pkg::CHAR_LF, 1'b1,
			framing_tags(hrf_pkg::CHAR_LF, 0, 1, 0, 0, 2));
		add_row(hrf_pkg::CMD_DATA, 8'h00, 1'b1, framing_tags(8'h00, 0, 0, 1, 0, 0));
		add_row(hrf_pkg::CMD_CLOSE, 8'hFF, 1'b1, '0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
		end
		run_phase();
		send_idle_pct = 64;
		stall_pct     = 13;
		run_phase();
		send_idle_pct = 0;
		stall_pct     = 0;
		run_phase();

		// let any stray response show up
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### files.f
rtl/hrf_pkg.sv
rtl/hrf_core.sv
rtl/http_request_framer.sv
rtl/hrf_checker.sv
tb/http_request_framer_test.sv
